/* rtl/chm_pkg.sv */
// chained_hash_map package: widths, operation codes and the miss code
// used by the chained_hash_map top level; no dependencies
package chm_pkg;

  localparam int unsigned BucketsDefault  = 1024;
  localparam int unsigned CapacityDefault = 1024;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned ValW  = 32;
  localparam int unsigned KindW = 2;

  localparam logic [KindW-1:0] KindLookup = 2'd0;
  localparam logic [KindW-1:0] KindInsert = 2'd1;
  localparam logic [KindW-1:0] KindDelete = 2'd2;

  localparam logic [ValW-1:0] MissCode = '1;

endpackage

/* rtl/chained_hash_map.sv */
// chained_hash_map: separate-chaining hash map from stripe number to buffer id
// depends on chm_pkg; all tables are internal memories with registered reads
//
//  channel | valid     | stall     | payload
//  in      | valid_i   | stall_o   | kind_i, stripe_id_i, buf_id_i
//  out     | valid_o   | stall_i   | hit_o, value_o, full_res_o
//
// the chain is walked one entry at a time (S_ERD, S_ECHK) through one read port;
// a delete hit or new insert also passes S_DEL; an unused kind goes straight to S_OUT
// stall_o is low only in S_IDLE: it rises after the accept and falls once the result word is taken
// after reset a clearing pass clears the head valid bits while the free stack is
// filled in parallel; init ends when both are done.
// the result word waits in an output register while stall_i is high.
module chained_hash_map #(
  parameter int unsigned BUCKETS  = chm_pkg::BucketsDefault,
  parameter int unsigned CAPACITY = chm_pkg::CapacityDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [chm_pkg::KindW-1:0] kind_i,
  input  logic [chm_pkg::KeyW-1:0] stripe_id_i,
  input  logic [chm_pkg::ValW-1:0] buf_id_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic                     hit_o,
  output logic [chm_pkg::ValW-1:0] value_o,
  output logic                     full_res_o
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned EW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (BW > EW) ? BW + 1 : EW + 1;
  localparam int unsigned KW = chm_pkg::KeyW;
  localparam int unsigned VW = chm_pkg::ValW;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HRD   = 4'd2;
  localparam logic [3:0] S_HCHK  = 4'd3;
  localparam logic [3:0] S_ERD   = 4'd4;
  localparam logic [3:0] S_ECHK  = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FWR   = 4'd7;
  localparam logic [3:0] S_DEL   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  // memories: head {ok, idx}, entry {key, val}, link {ok, idx}, free stack
  logic [EW:0]    head_mem [BUCKETS];
  logic           head_vld [BUCKETS];
  logic [KW-1:0]  key_mem  [CAPACITY];
  logic [VW-1:0]  val_mem  [CAPACITY];
  logic [EW:0]    link_mem [CAPACITY];
  logic [EW-1:0]  free_mem [CAPACITY];

  logic [3:0]    state_q, state_d;
  logic [IW-1:0] init_q, init_d;
  logic [CW-1:0] fcnt_q, fcnt_d;
  logic [CW-1:0] steps_q, steps_d;
  logic [chm_pkg::KindW-1:0] kind_q, kind_d;
  logic [KW-1:0] key_q, key_d;
  logic [VW-1:0] bval_q, bval_d;
  logic [BW-1:0] bkt_q, bkt_d;
  logic [EW-1:0] cur_q, cur_d, prev_q, prev_d;
  logic          prev_ok_q, prev_ok_d;
  logic          hit_q, hit_d, full_q, full_d;
  logic [VW-1:0] res_q, res_d;

  // registered read data
  logic [EW:0]   head_rd_q;
  logic          head_vld_rd_q;
  logic [KW-1:0] key_rd_q;
  logic [VW-1:0] val_rd_q;
  logic [EW:0]   link_rd_q;
  logic [EW-1:0] free_rd_q;

  // write strobes
  logic          head_we, link_we, ent_we, free_we;
  logic [BW-1:0] head_wa;
  logic [EW:0]   head_wd, link_wd;
  logic [EW-1:0] link_wa, ent_wa, free_wa, free_wd;
  logic [EW-1:0] ent_ra, free_ra;

  logic [BW-1:0] in_bkt;
  logic [KW-1:0] bkt_wide;

  assign bkt_wide = stripe_id_i % KW'(BUCKETS);
  assign in_bkt   = bkt_wide[BW-1:0];

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[bkt_q];
    if (ent_we) begin
      key_mem[ent_wa] <= key_q;
      val_mem[ent_wa] <= bval_q;
    end
    key_rd_q <= key_mem[ent_ra];
    val_rd_q <= val_mem[ent_ra];
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_q <= link_mem[ent_ra];
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd_q <= free_mem[free_ra];
  end

  // head valid bits are cleared by the init pass, so they need no reset
  always_ff @(posedge clk_i) begin
    if (state_q == S_INIT && init_q < IW'(BUCKETS)) head_vld[init_q[BW-1:0]] <= 1'b0;
    else if (head_we) head_vld[head_wa] <= 1'b1;
    head_vld_rd_q <= head_vld[bkt_q];
  end

  assign ent_ra  = cur_q;
  assign free_ra = EW'(fcnt_q - CW'(1));

  always_comb begin
    state_d = state_q; init_d = init_q; fcnt_d = fcnt_q; steps_d = steps_q;
    kind_d = kind_q; key_d = key_q; bval_d = bval_q; bkt_d = bkt_q;
    cur_d = cur_q; prev_d = prev_q; prev_ok_d = prev_ok_q;
    hit_d = hit_q; full_d = full_q; res_d = res_q;
    head_we = 1'b0; head_wa = bkt_q; head_wd = '0;
    link_we = 1'b0; link_wa = prev_q; link_wd = '0;
    ent_we = 1'b0; ent_wa = cur_q;
    free_we = 1'b0; free_wa = '0; free_wd = '0;
    unique case (state_q)
      S_INIT: begin
        if (init_q < IW'(CAPACITY)) begin
          free_we = 1'b1;
          free_wa = init_q[EW-1:0];
          free_wd = init_q[EW-1:0];
        end
        if (init_q >= IW'(BUCKETS - 1) && init_q >= IW'(CAPACITY - 1)) state_d = S_IDLE;
        init_d = init_q + IW'(1);
      end
      S_IDLE: begin
        if (valid_i) begin
          kind_d = kind_i; key_d = stripe_id_i; bval_d = buf_id_i; bkt_d = in_bkt;
          hit_d = 1'b0; full_d = 1'b0; res_d = chm_pkg::MissCode;
          prev_ok_d = 1'b0; prev_d = '0; steps_d = '0;
          // unused kind answers a miss at once
          if (kind_i == chm_pkg::KindLookup || kind_i == chm_pkg::KindInsert ||
              kind_i == chm_pkg::KindDelete) state_d = S_HRD;
          else state_d = S_OUT;
        end
      end
      S_HRD: state_d = S_HCHK;
      S_HCHK: begin
        if (head_vld_rd_q && head_rd_q[EW]) begin
          cur_d = head_rd_q[EW-1:0];
          state_d = S_ERD;
        end else state_d = S_FRD;
      end
      S_ERD: state_d = S_ECHK;
      S_ECHK: begin
        if (key_rd_q == key_q) begin
          hit_d = 1'b1;
          priority case (kind_q)
            chm_pkg::KindDelete: begin res_d = key_q; state_d = S_DEL; end
            default: begin res_d = val_rd_q; state_d = S_OUT; end
          endcase
        end else begin
          prev_ok_d = 1'b1; prev_d = cur_q;
          steps_d = steps_q + CW'(1);
          if (link_rd_q[EW] && steps_q + CW'(1) < CW'(CAPACITY)) begin
            cur_d = link_rd_q[EW-1:0];
            state_d = S_ERD;
          end else state_d = S_FRD;
        end
      end
      S_FRD: begin
        // miss: only an insert continues
        if (kind_q != chm_pkg::KindInsert) state_d = S_OUT;
        else if (fcnt_q == '0) begin full_d = 1'b1; state_d = S_OUT; end
        else state_d = S_FWR;
      end
      S_FWR: begin
        // new entry gets a cleared link here and is hooked onto the chain in S_DEL
        ent_we = 1'b1; ent_wa = free_rd_q;
        link_we = 1'b1; link_wa = free_rd_q; link_wd = '0;
        fcnt_d = fcnt_q - CW'(1);
        cur_d = free_rd_q;
        state_d = S_DEL;
      end
      S_DEL: begin
        if (kind_q == chm_pkg::KindInsert) begin
          if (prev_ok_q) begin
            link_we = 1'b1; link_wa = prev_q; link_wd = {1'b1, cur_q};
          end else begin
            head_we = 1'b1; head_wd = {1'b1, cur_q};
          end
        end else begin
          if (prev_ok_q) begin
            link_we = 1'b1; link_wa = prev_q; link_wd = link_rd_q;
          end else begin
            head_we = 1'b1; head_wd = link_rd_q;
          end
          if (fcnt_q < CW'(CAPACITY)) begin
            free_we = 1'b1; free_wa = fcnt_q[EW-1:0]; free_wd = cur_q;
            fcnt_d = fcnt_q + CW'(1);
          end
        end
        state_d = S_OUT;
      end
      S_OUT: if (!stall_i) state_d = S_IDLE;
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      init_q  <= '0;
      fcnt_q  <= CW'(CAPACITY);
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      fcnt_q  <= fcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q <= steps_d; kind_q <= kind_d; key_q <= key_d; bval_q <= bval_d;
    bkt_q <= bkt_d; cur_q <= cur_d; prev_q <= prev_d; prev_ok_q <= prev_ok_d;
    hit_q <= hit_d; full_q <= full_d; res_q <= res_d;
  end

  assign stall_o    = (state_q != S_IDLE);
  assign valid_o    = (state_q == S_OUT);
  assign hit_o      = hit_q;
  assign value_o    = res_q;
  assign full_res_o = full_q;

`ifndef SYNTHESIS
  a_full_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(hit_o && full_res_o)) else $error("full and hit together");
  a_fcnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= CW'(CAPACITY)) else $error("free count out of range");
  a_out_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(value_o)) else $error("result lost");
  a_miss_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !hit_o |-> value_o == chm_pkg::MissCode) else $error("miss value");
`endif

endmodule

/* tb/chained_hash_map_tb.sv */
// testbench for chained_hash_map: random and directed lookup, insert and delete words
// with a key-to-id map predictor; depends on chm_pkg and the chained_hash_map RTL
`timescale 1ns / 1ps
module chained_hash_map_tb;

  localparam logic [chm_pkg::KindW-1:0] KindUnused = 2'd3;
  localparam int unsigned Capacity = chm_pkg::CapacityDefault;

  typedef struct {
    logic [chm_pkg::KindW-1:0] kind;
    logic [chm_pkg::KeyW-1:0]  key;
    logic [chm_pkg::ValW-1:0]  id;
    bit                        drain;
  } op_t;

  typedef struct {
    logic                     hit;
    logic [chm_pkg::ValW-1:0] value;
    logic                     full;
  } map_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic [chm_pkg::KindW-1:0] kind_i = '0;
  logic [chm_pkg::KeyW-1:0] stripe_id_i = '0;
  logic [chm_pkg::ValW-1:0] buf_id_i = '0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o, hit_o, full_res_o;
  logic [chm_pkg::ValW-1:0] value_o;

  op_t pending_ops[$];
  map_res_t expected_res[$];
  logic [chm_pkg::ValW-1:0] id_by_key[logic [chm_pkg::KeyW-1:0]];
  int unsigned live_entries = 0;
  int unsigned n_sent = 0, n_checked = 0, n_hits = 0, n_full = 0;
  int unsigned n_errors = 0;
  bit quiet = 1'b0;

  chained_hash_map dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .kind_i(kind_i), .stripe_id_i(stripe_id_i), .buf_id_i(buf_id_i),
    .valid_o(valid_o), .stall_i(stall_i), .hit_o(hit_o), .value_o(value_o),
    .full_res_o(full_res_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // map semantics only: chain order and free stack order never show in a result
  function automatic map_res_t apply_op(input logic [chm_pkg::KindW-1:0] kind,
                                        input logic [chm_pkg::KeyW-1:0] key,
                                        input logic [chm_pkg::ValW-1:0] id);
    map_res_t r;
    bit present;
    r.hit = 1'b0;
    r.value = chm_pkg::MissCode;
    r.full = 1'b0;
    present = id_by_key.exists(key);
    case (kind)
      chm_pkg::KindLookup: begin
        if (present) begin
          r.hit = 1'b1;
          r.value = id_by_key[key];
        end
      end
      chm_pkg::KindInsert: begin
        if (present) begin
          r.hit = 1'b1;
          r.value = id_by_key[key];
        end else if (live_entries == Capacity) begin
          r.full = 1'b1;
        end else begin
          id_by_key[key] = id;
          live_entries++;
        end
      end
      chm_pkg::KindDelete: begin
        if (present) begin
          r.hit = 1'b1;
          r.value = key;
          id_by_key.delete(key);
          live_entries--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned gap;
    op_t nxt;
    bit offer;
    map_res_t r;
    if (!rst_ni) begin
      valid_i <= 1'b0;
      gap = 0;
    end else begin
      if (valid_i && !stall_o) begin
        r = apply_op(kind_i, stripe_id_i, buf_id_i);
        expected_res.push_back(r);
        n_sent++;
        if (r.hit) n_hits++;
        if (r.full) n_full++;
      end
      if (!(valid_i && stall_o)) begin
        offer = 1'b0;
        quiet = pending_ops.size() < 120;
        if (gap > 0) begin
          gap--;
        end else if (pending_ops.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(0, 3);
          end else if (!pending_ops[0].drain || expected_res.size() == 0) begin
            offer = 1'b1;
          end
        end
        if (offer) begin
          nxt = pending_ops.pop_front();
          kind_i <= nxt.kind;
          stripe_id_i <= nxt.key;
          buf_id_i <= nxt.id;
        end
        valid_i <= offer;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned burst;
    int unsigned hold;
    bit held_once;
    map_res_t e;
    if (!rst_ni) begin
      stall_i <= 1'b0;
      burst = 0;
      hold = 0;
      held_once = 1'b0;
    end else begin
      if (valid_o && !stall_i) begin
        if (expected_res.size() == 0) begin
          report($sformatf("unexpected word hit=%0b value=%h", hit_o, value_o));
        end else begin
          e = expected_res.pop_front();
          if (hit_o !== e.hit)
            report($sformatf("hit %b, expected %b", hit_o, e.hit));
          if (value_o !== e.value)
            report($sformatf("value %h, expected %h", value_o, e.value));
          if (full_res_o !== e.full)
            report($sformatf("full_res %b, expected %b", full_res_o, e.full));
          n_checked++;
        end
      end
      // one long hold so the block backs up into its input
      if (!held_once && n_sent >= 100) begin
        held_once = 1'b1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 3);
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  function automatic op_t mk(input logic [chm_pkg::KindW-1:0] kind,
                             input logic [chm_pkg::KeyW-1:0] key,
                             input logic [chm_pkg::ValW-1:0] id);
    op_t o;
    o.kind = kind;
    o.key = key;
    o.id = id;
    o.drain = 1'b0;
    return o;
  endfunction

  initial begin
    logic [chm_pkg::KeyW-1:0] key_pool[48];
    logic [chm_pkg::KeyW-1:0] fresh[$];
    logic [chm_pkg::KeyW-1:0] k;
    op_t o;
    int unsigned sel;
    // directed: extremes, collisions in one bucket, head, middle and tail deletes
    pending_ops.push_back(mk(chm_pkg::KindLookup, 32'h0, 32'h0));
    pending_ops.push_back(mk(chm_pkg::KindDelete, 32'hFFFF_FFFF, 32'h0));
    pending_ops.push_back(mk(chm_pkg::KindInsert, 32'h0, 32'hFFFF_FFFF));
    pending_ops.push_back(mk(chm_pkg::KindInsert, 32'hFFFF_FFFF, 32'h0));
    pending_ops.push_back(mk(chm_pkg::KindLookup, 32'h0, 32'h1234_5678));
    pending_ops.push_back(mk(chm_pkg::KindLookup, 32'hFFFF_FFFF, 32'h0));
    pending_ops.push_back(mk(chm_pkg::KindInsert, 32'h0, 32'h5555_5555));
    pending_ops.push_back(mk(chm_pkg::KindInsert, 32'd5, 32'hA5A5_0001));
    pending_ops.push_back(mk(chm_pkg::KindInsert, 32'd1029, 32'hA5A5_0002));
    pending_ops.push_back(mk(chm_pkg::KindInsert, 32'd2053, 32'hA5A5_0003));
    pending_ops.push_back(mk(chm_pkg::KindInsert, 32'd3077, 32'hA5A5_0004));
    pending_ops.push_back(mk(chm_pkg::KindLookup, 32'd3077, 32'h0));
    pending_ops.push_back(mk(chm_pkg::KindDelete, 32'd1029, 32'h0));
    pending_ops.push_back(mk(chm_pkg::KindLookup, 32'd2053, 32'h0));
    pending_ops.push_back(mk(chm_pkg::KindDelete, 32'd5, 32'h0));
    pending_ops.push_back(mk(chm_pkg::KindLookup, 32'd3077, 32'h0));
    pending_ops.push_back(mk(chm_pkg::KindDelete, 32'd3077, 32'h0));
    pending_ops.push_back(mk(chm_pkg::KindLookup, 32'd2053, 32'h0));
    pending_ops.push_back(mk(chm_pkg::KindInsert, 32'd5, 32'h0BAD_F00D));
    pending_ops.push_back(mk(chm_pkg::KindDelete, 32'd5, 32'h0));
    pending_ops.push_back(mk(chm_pkg::KindDelete, 32'd5, 32'h0));
    pending_ops.push_back(mk(KindUnused, 32'h0, 32'hFFFF_FFFF));
    pending_ops.push_back(mk(KindUnused, 32'hFFFF_FFFF, 32'h0));
    pending_ops.push_back(mk(chm_pkg::KindDelete, 32'hFFFF_FFFF, 32'h0));
    // a small key set packed into eight buckets gives chains of several entries
    foreach (key_pool[i])
      key_pool[i] = {22'($urandom()), 10'($urandom_range(0, 7) * 131)};
    for (int i = 0; i < 450; i++) begin
      sel = $urandom_range(0, 99);
      o = mk(sel < 35 ? chm_pkg::KindInsert : sel < 65 ? chm_pkg::KindLookup
             : sel < 97 ? chm_pkg::KindDelete : KindUnused,
             key_pool[$urandom_range(0, 47)], $urandom());
      if (i % 150 == 149) o.drain = 1'b1;
      pending_ops.push_back(o);
    end
    // fill the pool past capacity with fresh keys
    for (int i = 0; i < 1080; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        pending_ops.push_back(mk(chm_pkg::KindLookup, key_pool[$urandom_range(0, 47)],
                                 32'h0));
      end else begin
        k = $urandom();
        fresh.push_back(k);
        pending_ops.push_back(mk(chm_pkg::KindInsert, k, $urandom()));
      end
    end
    for (int i = 0; i < 130; i++) begin
      k = fresh[$urandom_range(0, fresh.size() - 1)];
      sel = $urandom_range(0, 3);
      pending_ops.push_back(mk(sel == 0 ? chm_pkg::KindInsert
                               : sel == 1 ? chm_pkg::KindLookup : chm_pkg::KindDelete,
                               sel == 0 && i % 2 == 0 ? $urandom() : k, $urandom()));
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pending_ops.size() != 0 || valid_i || expected_res.size() != 0);
    repeat (400) @(posedge clk_i);
    $display("covered %0d words: %0d hits, %0d dropped on a full pool, %0d results checked",
             n_sent, n_hits, n_full, n_checked);
    if (n_errors == 0 && expected_res.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
